// File: hdl/brl_pkg.sv
// Shared types and constants of the Bresenham line rasterizer.
`default_nettype none

package brl_pkg;

  // Coordinate width of endpoints and pixels.
  localparam int COORD_BITS = 16;
  // Differences are one bit wider than coordinates; the error term one more.
  localparam int DELTA_W = COORD_BITS + 1;
  localparam int ERR_W = COORD_BITS + 2;

  // Configuration registers.
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET = 11'd240;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 11'd320;

  // Width in which a non-negative coordinate is compared with a screen size.
  localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

  // Command queue between front and back; the depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [15:0]                  line_color;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [15:0]                  pixel_color;
    logic                         on_screen;
    logic                         last;
  } pixel_t;

  // A classified command: a step, or a start with its line setup worked out.
  typedef struct packed {
    op_t                          operation;
    logic                         steep;
    logic signed [COORD_BITS-1:0] major_start;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [COORD_BITS-1:0] minor_start;
    logic [DELTA_W-1:0]           delta_major;
    logic [DELTA_W-1:0]           delta_minor;
    logic                         minor_dir;
    logic [15:0]                  color;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
  } screen_cfg_t;

endpackage

`default_nettype wire

// File: hdl/brl_front.sv
// Front end: classifies an incoming word and works out the line setup for starts.
`default_nettype none

module brl_front (
  input  brl_pkg::item_t item,
  output brl_pkg::cmd_t  cmd
);
  import brl_pkg::*;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [DELTA_W-1:0]        adx;
  logic [DELTA_W-1:0]        ady;
  logic                      steep;
  logic signed [DELTA_W-1:0] diff_major;
  logic signed [DELTA_W-1:0] diff_minor;
  logic signed [COORD_BITS-1:0] major_a;
  logic signed [COORD_BITS-1:0] major_b;
  logic signed [COORD_BITS-1:0] minor_a;
  logic signed [COORD_BITS-1:0] minor_b;
  logic                      swap_ends;

  assign dx = DELTA_W'(item.end_x) - DELTA_W'(item.start_x);
  assign dy = DELTA_W'(item.end_y) - DELTA_W'(item.start_y);
  assign adx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign ady = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
  assign steep = ady > adx;

  always_comb begin
    if (steep) begin
      major_a = item.start_y;
      major_b = item.end_y;
      minor_a = item.start_x;
      minor_b = item.end_x;
      diff_major = dy;
      diff_minor = dx;
    end else begin
      major_a = item.start_x;
      major_b = item.end_x;
      minor_a = item.start_y;
      minor_b = item.end_y;
      diff_major = dx;
      diff_minor = dy;
    end
  end

  // The endpoints trade places when the major coordinate falls.
  assign swap_ends = diff_major[DELTA_W-1];

  always_comb begin
    cmd.operation = item.operation;
    cmd.steep = steep;
    cmd.major_start = swap_ends ? major_b : major_a;
    cmd.major_end = swap_ends ? major_a : major_b;
    cmd.minor_start = swap_ends ? minor_b : minor_a;
    cmd.delta_major = steep ? ady : adx;
    cmd.delta_minor = steep ? adx : ady;
    // Minus one unless the ordered minor coordinate strictly rises.
    if (swap_ends) begin
      cmd.minor_dir = !diff_minor[DELTA_W-1];
    end else begin
      cmd.minor_dir = diff_minor[DELTA_W-1] || (diff_minor == '0);
    end
    cmd.color = item.line_color;
  end

endmodule

`default_nettype wire

// File: hdl/brl_cmd_queue.sv
// Short command queue that decouples the front end from the stepper.
`default_nettype none

module brl_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brl_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output brl_pkg::cmd_t head,
  output logic          empty
);
  import brl_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/brl_back.sv
// Stepper: holds the running line, walks it one pixel per step and registers the output.
`default_nettype none

module brl_back (
  input  logic                clk,
  input  logic                rst,
  input  brl_pkg::screen_cfg_t cfg,
  input  brl_pkg::cmd_t       head,
  input  logic                head_empty,
  output logic                head_pop,
  output brl_pkg::pixel_t     pixel,
  output logic                empty,
  input  logic                pop
);
  import brl_pkg::*;

  logic                         active;
  logic                         steep_flag;
  logic signed [COORD_BITS-1:0] major_pos;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [COORD_BITS-1:0] minor_pos;
  logic signed [ERR_W-1:0]      error_acc;
  logic [DELTA_W-1:0]           delta_minor;
  logic signed [ERR_W-1:0]      delta_gap;
  logic                         minor_dir;
  logic [15:0]                  held_color;
  logic                         out_valid;

  logic                         is_start;
  logic                         out_free;
  logic                         emit;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         cur_last;
  logic                         visible;
  logic signed [ERR_W-1:0]      err_dec;
  logic signed [ERR_W-1:0]      err_wrap;

  assign is_start = (head.operation == OP_START);
  assign out_free = !out_valid || pop;
  // Starts always go; steps while idle are dropped; steps while active need a free slot.
  assign head_pop = !head_empty && (is_start || !active || out_free);
  assign emit = !head_empty && !is_start && active && out_free;

  assign px = steep_flag ? minor_pos : major_pos;
  assign py = steep_flag ? major_pos : minor_pos;
  assign cur_last = (major_pos >= major_end);
  assign visible = !px[COORD_BITS-1] && !py[COORD_BITS-1]
                && (CMP_W'(px[COORD_BITS-1:0]) < CMP_W'(cfg.screen_width))
                && (CMP_W'(py[COORD_BITS-1:0]) < CMP_W'(cfg.screen_height));

  // Both candidate errors are formed in parallel; the sign of the first selects.
  assign err_dec = error_acc - signed'(ERR_W'(delta_minor));
  assign err_wrap = error_acc + delta_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steep_flag <= 1'b0;
      major_pos <= '0;
      major_end <= '0;
      minor_pos <= '0;
      error_acc <= '0;
      delta_minor <= '0;
      delta_gap <= '0;
      minor_dir <= 1'b0;
      held_color <= '0;
    end else if (head_pop && is_start) begin
      active <= 1'b1;
      steep_flag <= head.steep;
      major_pos <= head.major_start;
      major_end <= head.major_end;
      minor_pos <= head.minor_start;
      error_acc <= signed'(ERR_W'(head.delta_major >> 1));
      delta_minor <= head.delta_minor;
      delta_gap <= signed'(ERR_W'(head.delta_major) - ERR_W'(head.delta_minor));
      minor_dir <= head.minor_dir;
      held_color <= head.color;
    end else if (emit) begin
      if (err_dec[ERR_W-1]) begin
        minor_pos <= minor_pos + (minor_dir ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        error_acc <= err_wrap;
      end else begin
        error_acc <= err_dec;
      end
      if (cur_last) begin
        active <= 1'b0;
      end else begin
        major_pos <= major_pos + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_x <= px;
      pixel.pixel_y <= py;
      pixel.pixel_color <= held_color;
      pixel.on_screen <= visible;
      pixel.last <= cur_last;
    end
  end

  assign empty = !out_valid;

  // The error term never stays negative while a line runs.
  assert property (@(posedge clk) disable iff (rst) active |-> !error_acc[ERR_W-1])
    else $error("error term negative on an active line");

  // The walk never passes the far endpoint.
  assert property (@(posedge clk) disable iff (rst) active |-> (major_pos <= major_end))
    else $error("major coordinate beyond line end");

  // Emitting the final pixel ends the line.
  assert property (@(posedge clk) disable iff (rst) (emit && cur_last) |=> !active)
    else $error("line still active after its last pixel");

endmodule

`default_nettype wire

// File: hdl/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: configuration, front end, queue and stepper.
`default_nettype none

// Integer Bresenham line rasterizer. A word with operation START loads two signed
// endpoints and a color and produces nothing; each following STEP word produces one
// pixel with its color, an on-screen flag (0 <= x < screen_width and
// 0 <= y < screen_height) and a last flag on the final pixel. STEP words with no line
// running are consumed and dropped, and a START during a line abandons it. Both
// sides behave as queues: a word is taken when push is high and full is low, and a
// pixel leaves when pop is high and empty is low. The block sustains one word per
// clock while pixels are popped: a START loads the stepper with no pixel, and each
// STEP yields one pixel. The rate is set by the stepper, whose error update per
// pixel is a subtract and an add formed in parallel and a select. A STEP word
// passes through a four-entry command queue and the output register before its
// pixel is on the pixel port and can be popped. The queue fills and raises full
// only when pixels are not popped. Screen registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is idle,
// which the block does not enforce. Indexes beyond the two registers are ignored.

module bresenham_line_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  brl_pkg::item_t                   item,
  output logic                             empty,
  input  logic                             pop,
  output brl_pkg::pixel_t                  pixel,
  input  logic                             cfg_write,
  input  logic [brl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [brl_pkg::CFG_W-1:0]        cfg_data
);
  import brl_pkg::*;

  screen_cfg_t cfg;
  cmd_t        front_cmd;
  cmd_t        head;
  logic        head_empty;
  logic        head_pop;

  // Screen size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width <= SCREEN_WIDTH_RESET;
      cfg.screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_WIDTH: cfg.screen_width <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end classifies each word and, for a start, orders the endpoints and
  // forms the deltas, so the stepper loads them and derives its error terms from them.
  brl_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  brl_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (head_pop),
    .head     (head),
    .empty    (head_empty)
  );

  // The stepper walks the line and owns the output register.
  brl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pixel      (pixel),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire
